// File: rtl/core/qa_pkg.sv
package qa_pkg;

    // Number of CORDIC rotation steps, one pipeline stage each (8 to 32).
    localparam int CORDIC_STEPS = 16;
    // Integer square root steps for a 64-bit radicand, one per stage.
    localparam int SQRT_STEPS = 32;

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic [32:0] DEG_TO_RAD = 33'd4797524518;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic [71:0]        prod;
        logic [63:0]        abcd;
        logic               neg;
        logic               inv;
    } cord_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
        logic        inv;
        logic        sat;
    } sq_t;

    // Truncated arctangent of 2^-i in Q2.30.
    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] r;
        r = '0;
        case (i)
            5'd0:  r = 34'sd843314856;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043836;
            5'd3:  r = 34'sd133525158;
            5'd4:  r = 34'sd67021686;
            5'd5:  r = 34'sd33543515;
            5'd6:  r = 34'sd16775850;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194282;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048575;
            5'd11: r = 34'sd524287;
            5'd12: r = 34'sd262143;
            5'd13: r = 34'sd131071;
            5'd14: r = 34'sd65535;
            5'd15: r = 34'sd32767;
            5'd16: r = 34'sd16383;
            5'd17: r = 34'sd8191;
            5'd18: r = 34'sd4095;
            5'd19: r = 34'sd2047;
            5'd20: r = 34'sd1023;
            5'd21: r = 34'sd511;
            5'd22: r = 34'sd255;
            5'd23: r = 34'sd127;
            5'd24: r = 34'sd63;
            5'd25: r = 34'sd31;
            5'd26: r = 34'sd15;
            5'd27: r = 34'sd7;
            5'd28: r = 34'sd3;
            5'd29: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/qa_front.sv
// Side terms, side products and angle reduction; three register stages.
module qa_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [15:0]          side_a,
    input  logic [15:0]          side_b,
    input  logic [15:0]          side_c,
    input  logic [15:0]          side_d,
    input  logic [14:0]          angle_first,
    input  logic [14:0]          angle_second,
    output logic                 out_valid,
    output qa_pkg::cord_t        out_data
);

    logic [15:0] side [4];
    logic [17:0] total;
    logic signed [18:0] term [4];
    logic [17:0] mag_next [4];
    logic        par_next, zero_next;
    logic [15:0] asum, u_mod, u_fold;
    logic [12:0] u_next;
    logic        neg_next;

    logic [17:0] mag_reg [4];
    logic        par_reg, zero_reg, neg1_reg, v1_reg;
    logic [31:0] ab_reg, cd_reg;
    logic [12:0] u_reg;

    logic [35:0] m12_reg, m34_reg;
    logic [63:0] abcd2_reg;
    logic signed [33:0] z2_reg;
    logic        inv2_reg, neg2_reg, v2_reg;
    logic [47:0] zprod;

    logic        v3_reg;
    qa_pkg::cord_t d3_reg;

    always_comb begin
        side[0] = side_a;
        side[1] = side_b;
        side[2] = side_c;
        side[3] = side_d;
        total = 18'(side_a) + 18'(side_b) + 18'(side_c) + 18'(side_d);
        par_next = 1'b0;
        zero_next = 1'b0;
        for (int i = 0; i < 4; i++) begin
            term[i] = $signed({1'b0, total}) - $signed({2'b00, side[i], 1'b0});
            mag_next[i] = term[i][18] ? 18'(-term[i]) : term[i][17:0];
            par_next = par_next ^ term[i][18];
            if (term[i] == 19'sd0) begin
                zero_next = 1'b1;
            end
        end
        // Angle sum modulo 360 degrees, then folded into the first quadrant.
        asum = 16'(angle_first) + 16'(angle_second);
        if (asum >= 16'd46080) begin
            u_mod = asum - 16'd46080;
        end else if (asum >= 16'd23040) begin
            u_mod = asum - 16'd23040;
        end else begin
            u_mod = asum;
        end
        u_fold = (u_mod > 16'd11520) ? 16'd23040 - u_mod : u_mod;
        neg_next = u_fold > 16'd5760;
        u_next = neg_next ? 13'(16'd11520 - u_fold) : u_fold[12:0];
    end

    assign zprod = 48'(u_reg) * 48'(qa_pkg::DEG_TO_RAD) + 48'd8192;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                mag_reg[i] <= mag_next[i];
            end
            par_reg  <= par_next;
            zero_reg <= zero_next;
            neg1_reg <= neg_next;
            u_reg    <= u_next;
            ab_reg   <= 32'(side_a) * 32'(side_b);
            cd_reg   <= 32'(side_c) * 32'(side_d);

            m12_reg   <= 36'(mag_reg[0]) * 36'(mag_reg[1]);
            m34_reg   <= 36'(mag_reg[2]) * 36'(mag_reg[3]);
            abcd2_reg <= 64'(ab_reg) * 64'(cd_reg);
            z2_reg    <= $signed(zprod[47:14]);
            inv2_reg  <= par_reg && !zero_reg;
            neg2_reg  <= neg1_reg;

            d3_reg.x    <= qa_pkg::CORDIC_X0;
            d3_reg.y    <= '0;
            d3_reg.z    <= z2_reg;
            d3_reg.prod <= 72'(m12_reg) * 72'(m34_reg);
            d3_reg.abcd <= abcd2_reg;
            d3_reg.neg  <= neg2_reg;
            d3_reg.inv  <= inv2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = d3_reg;

endmodule

// File: rtl/core/qa_cordic_stage.sv
// One rotation-mode CORDIC step; the step index is tied to a constant.
module qa_cordic_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic [4:0]    step,
    input  logic          in_valid,
    input  qa_pkg::cord_t in_data,
    output logic          out_valid,
    output qa_pkg::cord_t out_data
);

    qa_pkg::cord_t d_next, d_reg;
    logic          v_reg;
    logic signed [33:0] dx, dy;

    always_comb begin
        d_next = in_data;
        dx = in_data.y >>> step;
        dy = in_data.x >>> step;
        if (!in_data.z[33]) begin
            d_next.x = in_data.x - dx;
            d_next.y = in_data.y + dy;
            d_next.z = in_data.z - qa_pkg::atan_q30(step);
        end else begin
            d_next.x = in_data.x + dx;
            d_next.y = in_data.y - dy;
            d_next.z = in_data.z + qa_pkg::atan_q30(step);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

// File: rtl/core/qa_radicand.sv
// Cosine squared, the abcd term and the radicand with its flags; four stages.
module qa_radicand (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  qa_pkg::cord_t in_data,
    output logic          out_valid,
    output qa_pkg::sq_t   out_data
);

    logic [3:0]  v_reg;
    logic [30:0] xc;
    logic signed [31:0] c;
    logic signed [32:0] s33;

    logic [28:0] c2_reg;
    logic [63:0] abcd1_reg;
    logic [71:0] prod1_reg, prod2_reg, prod3_reg;
    logic [2:0]  inv_reg;
    logic [60:0] plo_reg, phi_reg;
    logic [95:0] cterm_reg;
    logic [95:0] p96, diff;
    logic        lt, inv_now;
    qa_pkg::sq_t d_reg;

    always_comb begin
        if (in_data.x[33]) begin
            xc = '0;
        end else if (in_data.x > 34'sd1073741824) begin
            xc = 31'd1073741824;
        end else begin
            xc = in_data.x[30:0];
        end
        c = in_data.neg ? -$signed({1'b0, xc}) : $signed({1'b0, xc});
        s33 = 33'sd1073741824 + 33'(c);
    end

    assign p96     = {prod3_reg, 24'd0};
    assign lt      = p96 < cterm_reg;
    assign diff    = p96 - cterm_reg;
    assign inv_now = inv_reg[2] || lt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c2_reg    <= s33[31:3];
            abcd1_reg <= in_data.abcd;
            prod1_reg <= in_data.prod;
            inv_reg   <= {inv_reg[1:0], in_data.inv};

            plo_reg   <= 61'(abcd1_reg[31:0]) * 61'(c2_reg);
            phi_reg   <= 61'(abcd1_reg[63:32]) * 61'(c2_reg);
            prod2_reg <= prod1_reg;

            cterm_reg <= 96'(plo_reg) + {3'd0, phi_reg, 32'd0};
            prod3_reg <= prod2_reg;

            d_reg.inv  <= inv_now;
            d_reg.sat  <= !inv_now && (diff[95:92] != 4'd0);
            d_reg.rem  <= diff[91:28];
            d_reg.root <= '0;
        end
    end

    assign out_valid = v_reg[3];
    assign out_data  = d_reg;

endmodule

// File: rtl/core/qa_sqrt_stage.sv
// One step of the bitwise integer square root.
module qa_sqrt_stage (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic [4:0]  step,
    input  logic        in_valid,
    input  qa_pkg::sq_t in_data,
    output logic        out_valid,
    output qa_pkg::sq_t out_data
);

    qa_pkg::sq_t d_next, d_reg;
    logic        v_reg;
    logic [5:0]  shamt;
    logic [63:0] bitv, trial;

    always_comb begin
        shamt = 6'd62 - {step, 1'b0};
        bitv  = 64'd1 << shamt;
        trial = in_data.root + bitv;
        d_next = in_data;
        if (in_data.rem >= trial) begin
            d_next.rem  = in_data.rem - trial;
            d_next.root = (in_data.root >> 1) + bitv;
        end else begin
            d_next.root = in_data.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

// File: rtl/core/quadrilateral_area_unit.sv
// Quadrilateral area by Bretschneider's formula. Each input transfer carries
// four unsigned Q8.8 side lengths and two opposite interior angles in units
// of 1/64 degree; each produces exactly one result transfer with the area in
// unsigned Q16.16 (floor of the exact root), an invalid-shape flag when the
// radicand is negative (area zero) and a saturation flag when the area does
// not fit in 32 bits (area all ones). The unit is fully pipelined: one item
// enters per clock unless the result side holds it off, and the pipeline depth
// is set by the CORDIC cosine chain and the 32-step square root, each stage of
// which is a register. All stages advance together whenever the output
// register is empty or its transfer completes, so back-pressure on the
// result side stalls the whole pipeline without loss.
module quadrilateral_area_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // side_a [15:0], side_b [31:16], side_c [47:32], side_d [63:48],
    // angle_first [78:64], angle_second [93:79], zero fill [95:94].
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // area_value [31:0].
    output logic [31:0] m_tdata,
    // invalid_shape [0], saturated [1].
    output logic [1:0]  m_tuser
);

    localparam int NC = qa_pkg::CORDIC_STEPS;
    localparam int NS = qa_pkg::SQRT_STEPS;

    // Global advance: every stage moves when the output slot frees up.
    logic en;
    logic out_valid_reg;
    logic [31:0] area_reg;
    logic inv_reg, sat_reg;

    logic          cv [NC+1];
    qa_pkg::cord_t cd [NC+1];
    logic          sv [NS+1];
    qa_pkg::sq_t   sd [NS+1];

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    qa_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_tvalid),
        .side_a       (s_tdata[15:0]),
        .side_b       (s_tdata[31:16]),
        .side_c       (s_tdata[47:32]),
        .side_d       (s_tdata[63:48]),
        .angle_first  (s_tdata[78:64]),
        .angle_second (s_tdata[93:79]),
        .out_valid    (cv[0]),
        .out_data     (cd[0])
    );

    // The cosine of the folded angle sum, one CORDIC step per stage.
    for (genvar i = 0; i < NC; i++) begin : g_cordic
        qa_cordic_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .step      (5'(i)),
            .in_valid  (cv[i]),
            .in_data   (cd[i]),
            .out_valid (cv[i+1]),
            .out_data  (cd[i+1])
        );
    end

    qa_radicand u_radicand (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cv[NC]),
        .in_data   (cd[NC]),
        .out_valid (sv[0]),
        .out_data  (sd[0])
    );

    // The floor square root, one result bit per stage.
    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        qa_sqrt_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .step      (5'(k)),
            .in_valid  (sv[k]),
            .in_data   (sd[k]),
            .out_valid (sv[k+1]),
            .out_data  (sd[k+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= sv[NS];
        end
    end

    // Flags override the root: invalid forces zero, saturation all ones.
    always_ff @(posedge aclk) begin
        if (en) begin
            inv_reg <= sd[NS].inv;
            sat_reg <= sd[NS].sat;
            if (sd[NS].inv) begin
                area_reg <= '0;
            end else if (sd[NS].sat) begin
                area_reg <= '1;
            end else begin
                area_reg <= sd[NS].root[31:0];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = area_reg;
    assign m_tuser  = {sat_reg, inv_reg};

endmodule

// File: rtl/core/qa_checker.sv
module qa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A result that is not taken stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The two flags exclude each other.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("invalid and saturated together");

    // An invalid shape reports zero area; saturation reports all ones.
    a_area: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tuser[0] || m_tdata == 32'd0)
                  && (!m_tuser[1] || m_tdata == 32'hFFFF_FFFF))
        else $error("area disagrees with flags");

    // The input side is ready whenever the output slot is free.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with free output");

endmodule

bind quadrilateral_area_unit qa_checker u_qa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/quadrilateral_area_checker.sv
module quadrilateral_area_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          mismatch_count,
    output int          areas_pending
);

    typedef struct packed {
        logic [31:0] area;
        logic        invalid;
        logic        sat;
    } area_result_t;

    area_result_t area_queue[$];

    localparam longint ATAN_TABLE [32] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 7, 3, 1, 0, 0
    };

    // Cosine squared of half the angle sum, in Q.28.
    function automatic logic [63:0] half_angle_cos_sq(input logic [31:0] angle_sum);
        logic [31:0] u;
        logic        neg;
        logic [63:0] zu;
        longint      x, y, z, dx, dy, c;
        u   = angle_sum % 23040;
        neg = 1'b0;
        if (u > 11520) u = 23040 - u;
        if (u > 5760) begin
            u   = 11520 - u;
            neg = 1'b1;
        end
        zu = ((64'(u) * 64'd4797524518) + 64'd8192) >> 14;
        z  = longint'(zu);
        x  = 652032874;
        y  = 0;
        for (int i = 0; i < qa_pkg::CORDIC_STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - ATAN_TABLE[i];
            end else begin
                x = x + dx; y = y - dy; z = z + ATAN_TABLE[i];
            end
        end
        if (x < 0) x = 0;
        if (x > (64'd1 << 30)) x = longint'(64'd1 << 30);
        c = neg ? -x : x;
        return 64'(longint'(64'd1 << 30) + c) >> 3;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] rem, root, bitv;
        rem  = v;
        root = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic area_result_t predict_area(input logic [95:0] d);
        logic [63:0]  side [4];
        logic [63:0]  mag [4];
        longint       total, t;
        int           negs;
        logic         zero_term;
        logic [127:0] prod, cterm, rad;
        logic [63:0]  abcd;
        logic [31:0]  asum;
        area_result_t r;
        total     = 0;
        negs      = 0;
        zero_term = 1'b0;
        for (int i = 0; i < 4; i++) begin
            side[i] = 64'(d[16*i +: 16]);
            total   = total + longint'(side[i]);
        end
        for (int i = 0; i < 4; i++) begin
            t = total - 2 * longint'(side[i]);
            if (t < 0) begin
                negs++;
                mag[i] = 64'(-t);
            end else begin
                mag[i] = 64'(t);
            end
            if (t == 0) zero_term = 1'b1;
        end
        prod  = (128'(mag[0] * mag[1]) * 128'(mag[2] * mag[3])) << 24;
        abcd  = (side[0] * side[1]) * (side[2] * side[3]);
        asum  = 32'(d[78:64]) + 32'(d[93:79]);
        cterm = 128'(abcd) * 128'(half_angle_cos_sq(asum));
        r = '0;
        if ((!zero_term && negs[0]) || prod < cterm) begin
            r.invalid = 1'b1;
        end else begin
            rad = (prod - cterm) >> 28;
            if (rad[127:64] != 0) begin
                r.area = 32'hFFFFFFFF;
                r.sat  = 1'b1;
            end else begin
                r.area = 32'(floor_sqrt(rad[63:0]));
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        area_result_t exp_r;
        if (!aresetn) begin
            mismatch_count = 0;
            area_queue.delete();
        end else begin
            if (s_tvalid && s_tready) area_queue.push_back(predict_area(s_tdata));
            if (m_tvalid && m_tready) begin
                if (area_queue.size() == 0) begin
                    report_mismatch("unexpected transfer", m_tdata, 32'd0);
                end else begin
                    exp_r = area_queue.pop_front();
                    if (m_tdata !== exp_r.area)
                        report_mismatch("area_value", m_tdata, exp_r.area);
                    if (m_tuser[0] !== exp_r.invalid)
                        report_mismatch("invalid_shape", 32'(m_tuser[0]),
                                        32'(exp_r.invalid));
                    if (m_tuser[1] !== exp_r.sat)
                        report_mismatch("saturated", 32'(m_tuser[1]), 32'(exp_r.sat));
                end
            end
        end
        areas_pending = area_queue.size();
    end
endmodule

// File: tb/tb_quadrilateral_area_unit.sv
module tb_quadrilateral_area_unit;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // side_a, side_b, side_c, side_d, angle_first, angle_second, zero fill.
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // area_value.
    logic [31:0] m_tdata;
    // invalid_shape, saturated.
    logic [1:0]  m_tuser;

    int     mismatch_count;
    int     areas_pending;
    int     cycle_count;
    // When set, both sides run without gaps.
    logic   burst_mode;
    // A request from the stimulus for one long receiver hold-off.
    logic   hold_request;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 80;

    quadrilateral_area_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    quadrilateral_area_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .areas_pending  (areas_pending)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // The watchdog ends a hung run with the fail verdict.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("quadrilateral_area_unit regression: fail");
            $finish;
        end
    end

    function automatic int draw_gap();
        return burst_mode ? 0 : $urandom_range(0, 18);
    endfunction

    // Offers one item after an idle gap. The valid is only lowered while
    // the gap runs, so a back-to-back transfer keeps it high.
    task automatic send_geometry(input logic [95:0] item);
        int gap;
        gap = draw_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [95:0] pack_geometry(input logic [15:0] a, b, c, d,
                                                  input logic [14:0] p, q);
        return {2'b00, q, p, d, c, b, a};
    endfunction

    // Mostly closed shapes at a random scale, so that the radicand is often
    // positive; the rest is raw noise across every bit of every field.
    function automatic logic [95:0] random_geometry();
        logic [15:0] s [4];
        logic [14:0] p, q;
        int          scale;
        int          pick;
        pick  = $urandom_range(0, 9);
        scale = $urandom_range(0, 12);
        for (int i = 0; i < 4; i++) begin
            if (pick < 7) s[i] = 16'(($urandom_range(16384, 65535)) >> scale);
            else s[i] = 16'($urandom);
        end
        if ($urandom_range(0, 4) == 0) begin
            p = 15'($urandom);
            q = 15'($urandom);
        end else begin
            p = 15'($urandom_range(0, 23040));
            q = 15'($urandom_range(0, 23040));
        end
        return pack_geometry(s[0], s[1], s[2], s[3], p, q);
    endfunction

    // Result-side pacing, with one long hold-off on request.
    initial begin
        int   gap;
        logic hold_done;
        m_tready  = 1'b0;
        hold_done = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_request && !hold_done) begin
                repeat (400) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                end
                hold_done = 1'b1;
            end
            gap = draw_gap();
            repeat (gap) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        logic [95:0] directed [$];
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        burst_mode   = 1'b0;
        hold_request = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed shapes: all zero, a unit square, the largest sides with
        // the cosine term at zero, one and its most negative fold, a side
        // equal to the sum of the others, an open shape, angle sums that
        // wrap past a full turn, and the widest angle codes.
        directed.push_back(pack_geometry(0, 0, 0, 0, 0, 0));
        directed.push_back(pack_geometry(256, 256, 256, 256, 5760, 5760));
        directed.push_back(pack_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                         5760, 5760));
        directed.push_back(pack_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0));
        directed.push_back(pack_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                         11520, 0));
        directed.push_back(pack_geometry(768, 256, 256, 256, 5760, 5760));
        directed.push_back(pack_geometry(4000, 100, 100, 100, 3000, 3000));
        directed.push_back(pack_geometry(16'hFFFF, 0, 0, 0, 0, 0));
        directed.push_back(pack_geometry(300, 400, 300, 400, 23040, 23040));
        directed.push_back(pack_geometry(300, 400, 300, 400, 15'h7FFF, 15'h7FFF));
        directed.push_back(pack_geometry(300, 400, 500, 600, 0, 23040));
        directed.push_back(pack_geometry(1, 1, 1, 1, 5760, 5760));
        directed.push_back(pack_geometry(1000, 1000, 1000, 1000, 2880, 8640));
        directed.push_back(pack_geometry(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                         15'h4000, 15'h2AAA));
        directed.push_back(pack_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE,
                                         15'h5555, 15'h2AAA));
        foreach (directed[i]) send_geometry(directed[i]);

        // Back-to-back burst with a long result stall, so that the pipeline
        // fills up and holds its input.
        burst_mode   = 1'b1;
        hold_request = 1'b1;
        repeat (150) send_geometry(random_geometry());
        burst_mode = 1'b0;

        repeat (350) send_geometry(random_geometry());

        // Let every outstanding area come back before going on.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (areas_pending != 0) @(posedge aclk);

        burst_mode = 1'b1;
        repeat (150) send_geometry(random_geometry());
        burst_mode = 1'b0;
        repeat (300) send_geometry(random_geometry());
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (areas_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("quadrilateral_area_unit regression: pass");
        end else begin
            $display("quadrilateral_area_unit regression: fail");
        end
        $finish;
    end
endmodule
